### rtl/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg
// Shared types and codes for the sorted table with ordered insert and search.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int unsigned ValueW  = 16;
  localparam int unsigned PosW    = 10;
  localparam int unsigned StatusW = 2;

  // Operation codes carried on kind_i.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // Result status codes.
  localparam logic [StatusW-1:0] STATUS_OK   = 2'd0;
  localparam logic [StatusW-1:0] STATUS_MISS = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_INS_CMP  = 5'b00010,
    ST_INS_WR   = 5'b00100,
    ST_SRCH_RD  = 5'b01000,
    ST_SRCH_CMP = 5'b10000
  } state_e;

endpackage

### rtl/sti_ram.sv
// ----------------------------------------------------------------------------
// sti_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sti_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sorted_table_insert_and_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_and_binary_search
// Ascending table of unsigned keys in a RAM with a fill count. Inserts shift
// larger keys up one slot at a time; lookups run a binary search.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o | kind_i (1), value_i (16)
//  out     | out_valid_o/out_ready_i | status_o (2), position_o (10)
//
// An insert moves each larger stored key up one slot, then writes the new key;
// an insert into a full table answers STATUS_FULL straight from idle. A lookup
// reads each probe from the RAM, then compares it; at most log2(DEPTH)+1 probes.
// The single table RAM read port and the one key comparator serialize them.
// Reset empties the table at once by clearing the fill count.
// One item is in work at a time; a new transfer is taken once the previous
// result has been taken, or in the same cycle as it is taken.
// ----------------------------------------------------------------------------
module sorted_table_insert_and_binary_search
  import sti_pkg::*;
#(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [ValueW-1:0]  value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [PosW-1:0]    position_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         slot_q, slot_d;
  logic [CW-1:0]         lo_q, lo_d;
  logic [CW-1:0]         hi_q, hi_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic                  out_valid_q, out_valid_d;
  logic [StatusW-1:0]    status_q, status_d;
  logic [PosW-1:0]       pos_q, pos_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic [63:0]           value_ext;
  logic [VALUE_BITS-1:0] value_key;
  logic                  in_xfer;
  logic                  key_lt;
  logic                  key_eq;
  logic [CW-1:0]         count_m1;
  logic [AW-1:0]         slot_m1;
  logic [CW:0]           mid_sum;
  logic [AW-1:0]         mid;
  logic [31:0]           slot_ext;

  assign value_ext = 64'(value_i);
  assign value_key = value_ext[VALUE_BITS-1:0];

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;

  // The one shared comparator: key against the word read from the table.
  assign key_lt = key_q < ram_rdata;
  assign key_eq = key_q == ram_rdata;

  assign count_m1 = count_q - CW'(1);
  assign slot_m1  = slot_q - AW'(1);
  assign slot_ext = 32'(slot_q);

  // hi_q is the exclusive upper bound, so the midpoint is (lo + hi - 1) / 2.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
  assign mid     = mid_sum[AW:1];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    slot_d      = slot_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    key_d       = key_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    pos_d       = pos_q;
    ram_we      = 1'b0;
    ram_waddr   = slot_q;
    ram_wdata   = key_q;
    ram_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        ram_raddr = count_m1[AW-1:0];
        if (in_xfer) begin
          key_d = value_key;
          if (kind_i == KIND_SEARCH) begin
            lo_d    = '0;
            hi_d    = count_q;
            state_d = ST_SRCH_RD;
          end else if (count_q == CW'(DEPTH)) begin
            out_valid_d = 1'b1;
            status_d    = STATUS_FULL;
            pos_d       = '0;
          end else if (count_q == '0) begin
            slot_d  = '0;
            state_d = ST_INS_WR;
          end else begin
            // The last filled entry is read now and compared next cycle.
            slot_d  = count_q[AW-1:0];
            state_d = ST_INS_CMP;
          end
        end
      end

      ST_INS_CMP: begin
        ram_raddr = slot_m1 - AW'(1);
        if (key_lt) begin
          // Move the larger entry up; the read of the next one is already out.
          ram_we    = 1'b1;
          ram_waddr = slot_q;
          ram_wdata = ram_rdata;
          slot_d    = slot_m1;
          if (slot_m1 == '0) begin
            state_d = ST_INS_WR;
          end
        end else begin
          ram_we      = 1'b1;
          count_d     = count_q + CW'(1);
          out_valid_d = 1'b1;
          status_d    = STATUS_OK;
          pos_d       = slot_ext[PosW-1:0];
          state_d     = ST_IDLE;
        end
      end

      ST_INS_WR: begin
        ram_we      = 1'b1;
        count_d     = count_q + CW'(1);
        out_valid_d = 1'b1;
        status_d    = STATUS_OK;
        pos_d       = slot_ext[PosW-1:0];
        state_d     = ST_IDLE;
      end

      ST_SRCH_RD: begin
        ram_raddr = mid;
        if (lo_q < hi_q) begin
          slot_d  = mid;
          state_d = ST_SRCH_CMP;
        end else begin
          out_valid_d = 1'b1;
          status_d    = STATUS_MISS;
          pos_d       = '0;
          state_d     = ST_IDLE;
        end
      end

      ST_SRCH_CMP: begin
        if (key_eq) begin
          out_valid_d = 1'b1;
          status_d    = STATUS_OK;
          pos_d       = slot_ext[PosW-1:0];
          state_d     = ST_IDLE;
        end else if (key_lt) begin
          hi_d    = CW'(slot_q);
          state_d = ST_SRCH_RD;
        end else begin
          lo_d    = CW'(slot_q) + CW'(1);
          state_d = ST_SRCH_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    key_q    <= key_d;
    status_q <= status_d;
    pos_q    <= pos_d;
  end

  sti_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;

endmodule

### rtl/sti_checker.sv
// ----------------------------------------------------------------------------
// sti_checker
// Port-level checks on the sorted table, bound to its top level.
// ----------------------------------------------------------------------------
module sti_checker
  import sti_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               kind_i,
  input logic [ValueW-1:0]  value_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [StatusW-1:0] status_o,
  input logic [PosW-1:0]    position_o
);

  // A result waiting to be taken holds its payload.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(position_o))
    else $error("result changed while stalled");

  // Only the three defined status codes are ever shown.
  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_OK || status_o == STATUS_MISS ||
                     status_o == STATUS_FULL))
    else $error("undefined status code");

  // Misses and full-table answers carry position zero.
  a_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> position_o == '0)
    else $error("non-zero position on a failed operation");

  // No new transfer is taken while a result is pending and not being taken.
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result pending");

endmodule

bind sorted_table_insert_and_binary_search sti_checker u_sti_checker (.*);
